// ===== rtl/wbps_pkg.sv =====
// shared types and register indexes for the wildcard byte pattern scanner
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package wbps_pkg;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int ADDR_W     = 48;
    localparam int POS_W      = 32;
    localparam int ADJ_W      = 32;
    localparam int PAT_BYTES  = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_PATTERN_LOW    = 3'd0;
    localparam t_cfg_idx CFG_PATTERN_HIGH   = 3'd1;
    localparam t_cfg_idx CFG_WILDCARD_MASK  = 3'd2;
    localparam t_cfg_idx CFG_PATTERN_LENGTH = 3'd3;
    localparam t_cfg_idx CFG_BASE_ADDRESS   = 3'd4;
    localparam t_cfg_idx CFG_ADDRESS_ADJUST = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       region_end;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  match_position;
        logic [ADDR_W-1:0] match_address;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/wbps_front.sv =====
// front part: byte window, region byte count, masked compare and request classification
// depends on wbps_pkg; feeds the event queue (wbps_fifo)
`timescale 1ns / 1ps
`default_nettype none

module wbps_front #(
    parameter int MAX_PATTERN = 16,
    parameter int COUNT_BITS  = 32,
    parameter int LEN_W       = 5
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire wbps_pkg::t_in_item    i_in_item,
    input  wire logic                  i_cfg_we,
    input  wire logic [127:0]          i_pattern,
    input  wire logic [15:0]           i_wild,
    input  wire logic [4:0]            i_len,
    output logic [LEN_W-1:0]           o_eff_len,
    input  wire logic                  i_full,
    output logic                       o_push,
    output logic                       o_push_found,
    output logic [COUNT_BITS-1:0]      o_push_count
);
    import wbps_pkg::*;

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [7:0]            w_pb [MAX_PATTERN];
    logic                  w_wb [MAX_PATTERN];

    // pattern aligned to window entries, refreshed every cycle from the registers
    logic [7:0]            r_exp  [MAX_PATTERN];
    logic [7:0]            n_exp  [MAX_PATTERN];
    logic                  r_care [MAX_PATTERN];
    logic                  n_care [MAX_PATTERN];
    logic [LEN_W-1:0]      r_eff_len;
    logic [LEN_W-1:0]      n_eff_len;
    logic                  r_busy;

    logic [7:0]            r_win [MAX_PATTERN];
    logic [7:0]            n_win [MAX_PATTERN];
    logic [COUNT_BITS-1:0] r_cnt;
    logic [COUNT_BITS-1:0] n_cnt;
    logic                  r_done;

    logic [MAX_PATTERN-1:0] w_ok;
    logic                   w_hit;
    logic                   w_accept;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pat
        if (k < PAT_BYTES) begin : g_cfg
            assign w_pb[k] = i_pattern[8*k +: 8];
            assign w_wb[k] = i_wild[k];
        end else begin : g_zero
            assign w_pb[k] = 8'd0;
            assign w_wb[k] = 1'b0;
        end
    end

    // length 0 behaves as 1, anything above the window size is clamped
    always_comb begin
        if (i_len == 5'd0) begin
            n_eff_len = LEN_W'(1);
        end else if (int'(i_len) > MAX_PATTERN) begin
            n_eff_len = LEN_W'(MAX_PATTERN);
        end else begin
            n_eff_len = LEN_W'(i_len);
        end
    end

    // window entry j (0 newest) lines up with pattern byte len-1-j
    always_comb begin
        for (int j = 0; j < MAX_PATTERN; j++) begin
            n_exp[j]  = 8'd0;
            n_care[j] = 1'b0;
            if (j < int'(n_eff_len)) begin
                n_exp[j]  = w_pb[IDX_W'(int'(n_eff_len) - 1 - j)];
                n_care[j] = !w_wb[IDX_W'(int'(n_eff_len) - 1 - j)];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_exp     <= n_exp;
        r_care    <= n_care;
        r_eff_len <= n_eff_len;
    end

    // hold off input in the cycle after a write so the aligned pattern catches up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= i_cfg_we;
        end
    end

    assign o_in_ready = !r_busy && !i_full;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_win[0] = i_in_item.data_byte;
        for (int j = 1; j < MAX_PATTERN; j++) begin
            n_win[j] = r_win[j-1];
        end
        n_cnt = (r_cnt == '1) ? r_cnt : r_cnt + COUNT_BITS'(1);
        for (int j = 0; j < MAX_PATTERN; j++) begin
            w_ok[j] = !r_care[j] || (n_win[j] == r_exp[j]);
        end
        w_hit = (&w_ok) && (n_cnt >= COUNT_BITS'(r_eff_len));
    end

    // window entries outside the current region never matter: the count guards them
    always_ff @(posedge i_clk) begin
        if (w_accept && !r_done) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (w_accept) begin
            if (i_in_item.region_end) begin
                r_cnt  <= '0;
                r_done <= 1'b0;
            end else if (!r_done) begin
                r_cnt  <= n_cnt;
                r_done <= w_hit;
            end
        end
    end

    assign o_push       = w_accept && !r_done && (w_hit || i_in_item.region_end);
    assign o_push_found = w_hit;
    assign o_push_count = n_cnt;
    assign o_eff_len    = r_eff_len;

endmodule

`default_nettype wire

// ===== rtl/wbps_fifo.sv =====
// short event queue between the front and back parts
// no dependencies beyond the package
`timescale 1ns / 1ps
`default_nettype none

module wbps_fifo #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data,
    input  wire logic             i_pop
);
    import wbps_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wbps_back.sv =====
// back part: position and address arithmetic in two stages, the second being the output register
// depends on wbps_pkg; fed from the event queue
`timescale 1ns / 1ps
`default_nettype none

module wbps_back #(
    parameter int COUNT_BITS = 32,
    parameter int LEN_W      = 5
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic                      i_found,
    input  wire logic [COUNT_BITS-1:0]     i_count,
    input  wire logic [LEN_W-1:0]          i_eff_len,
    input  wire logic [47:0]               i_base,
    input  wire logic [31:0]               i_adj,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output wbps_pkg::t_out_item            o_out_item
);
    import wbps_pkg::*;

    logic                  r_s1_valid;
    logic                  r_s1_found;
    logic [COUNT_BITS-1:0] r_s1_pos;
    logic [ADDR_W-1:0]     r_s1_sum;
    logic                  r_o_valid;
    t_out_item             r_o_item;
    logic                  w_s2_ready;
    logic                  w_take;
    logic                  w_adv;

    assign w_s2_ready = !r_o_valid || i_out_ready;
    assign o_ready    = !r_s1_valid || w_s2_ready;
    assign w_take     = i_valid && o_ready;
    assign w_adv      = r_s1_valid && w_s2_ready;

    // stage 1: match start and base plus signed adjust, both zero when not found
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s1_found <= i_found;
            r_s1_pos   <= i_found ? i_count - COUNT_BITS'(i_eff_len) : '0;
            r_s1_sum   <= i_found ? i_base + ADDR_W'($signed(i_adj)) : '0;
        end
    end

    // stage 2: final address, wraps at 48 bits
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_item.found          <= r_s1_found;
            r_o_item.match_position <= POS_W'(r_s1_pos);
            r_o_item.match_address  <= r_s1_sum + ADDR_W'(r_s1_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (w_s2_ready) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_item  = r_o_item;

endmodule

`default_nettype wire

// ===== rtl/wildcard_byte_pattern_scanner_unit.sv =====
// top level of the wildcard byte pattern scanner: config registers and the three parts
// depends on wbps_pkg, wbps_front, wbps_fifo, wbps_back
//
// usage
//   input channel (i_in_valid / o_in_ready / i_in_item) takes one memory byte per
//   request, with region_end marking the last byte of a region
//   output channel (o_out_valid / i_out_ready / o_out_item) gives at most one result
//   per region: the first match, or a not-found result on the region end byte
//   config port (i_cfg_we / i_cfg_idx / i_cfg_data) writes one register per cycle,
//   used only while the block is idle; input ready drops for the cycle after a write
// throughput
//   one byte per cycle whenever input ready is high; one parallel masked window compare per byte
// result path
//   a result goes from the byte that caused it through the queue, then the address
//   stage, then the output register
// reset
//   synchronous active low; clears config (pattern length goes to 1), count, match flag,
//   queue and valids; input ready stays low until the busy flag set in reset clears
// receiver stall
//   the output register holds; the two-entry queue and the address stage absorb
//   results, and input ready drops only once the queue is full
`timescale 1ns / 1ps
`default_nettype none

module wildcard_byte_pattern_scanner_unit #(
    parameter int MAX_PATTERN = 16,
    parameter int COUNT_BITS  = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire wbps_pkg::t_in_item             i_in_item,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output wbps_pkg::t_out_item                 o_out_item,
    input  wire logic                           i_cfg_we,
    input  wire wbps_pkg::t_cfg_idx             i_cfg_idx,
    input  wire logic [wbps_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import wbps_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int EVT_W = 1 + COUNT_BITS;

    // configuration registers
    logic [63:0]           r_pat_lo;
    logic [63:0]           r_pat_hi;
    logic [15:0]           r_wild;
    logic [4:0]            r_len;
    logic [ADDR_W-1:0]     r_base;
    logic [ADJ_W-1:0]      r_adj;

    // front to queue
    logic                  w_push;
    logic                  w_push_found;
    logic [COUNT_BITS-1:0] w_push_count;
    logic                  w_full;
    logic [LEN_W-1:0]      w_eff_len;

    // queue to back
    logic                  w_q_valid;
    logic [EVT_W-1:0]      w_q_data;
    logic                  w_back_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_wild   <= '0;
            r_len    <= 5'd1;
            r_base   <= '0;
            r_adj    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PATTERN_LOW:    r_pat_lo <= i_cfg_data;
                CFG_PATTERN_HIGH:   r_pat_hi <= i_cfg_data;
                CFG_WILDCARD_MASK:  r_wild   <= i_cfg_data[15:0];
                CFG_PATTERN_LENGTH: r_len    <= i_cfg_data[4:0];
                CFG_BASE_ADDRESS:   r_base   <= i_cfg_data[ADDR_W-1:0];
                CFG_ADDRESS_ADJUST: r_adj    <= i_cfg_data[ADJ_W-1:0];
                default: ;  // unused indexes are dropped
            endcase
        end
    end

    // front: window shift, saturating count, compare, decides whether a byte makes a result
    wbps_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .COUNT_BITS  (COUNT_BITS),
        .LEN_W       (LEN_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_cfg_we     (i_cfg_we),
        .i_pattern    ({r_pat_hi, r_pat_lo}),
        .i_wild       (r_wild),
        .i_len        (r_len),
        .o_eff_len    (w_eff_len),
        .i_full       (w_full),
        .o_push       (w_push),
        .o_push_found (w_push_found),
        .o_push_count (w_push_count)
    );

    // queue carries found flag and the byte count at the deciding byte
    wbps_fifo #(
        .WIDTH (EVT_W),
        .DEPTH (2)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_push_found, w_push_count}),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .i_pop   (w_back_ready)
    );

    // back: position, address arithmetic, output register
    wbps_back #(
        .COUNT_BITS (COUNT_BITS),
        .LEN_W      (LEN_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .o_ready     (w_back_ready),
        .i_found     (w_q_data[EVT_W-1]),
        .i_count     (w_q_data[COUNT_BITS-1:0]),
        .i_eff_len   (w_eff_len),
        .i_base      (r_base),
        .i_adj       (r_adj),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

// ===== rtl/wbps_chk.sv =====
// port-level checker for the scanner, bound to the top level
// depends on wbps_pkg and wildcard_byte_pattern_scanner_unit
`timescale 1ns / 1ps
`default_nettype none

module wbps_chk (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_in_ready,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_ready,
    input wire wbps_pkg::t_out_item  o_out_item,
    input wire logic                 i_cfg_we
);
    import wbps_pkg::*;

    // no result is left over from before a reset
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a not-found result carries zero position and address
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.found) |->
            (o_out_item.match_position == '0 && o_out_item.match_address == '0))
        else $error("not-found result with nonzero fields");

    // input is closed for the cycle after a config write
    a_cfg_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_in_ready)
        else $error("input ready right after config write");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("output changed while stalled");

endmodule

bind wildcard_byte_pattern_scanner_unit wbps_chk u_wbps_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item),
    .i_cfg_we    (i_cfg_we)
);

`default_nettype wire
